// File: sv/cetl_pkg.sv
// ----------------------------------------------------------------------------
// cetl_pkg
// Shared types and constants of the thick line clip and expand block.
// ----------------------------------------------------------------------------
package cetl_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int T_BITS        = 30;
    localparam int CRD_W         = 32;
    localparam int COL_W         = 24;
    localparam int CFG_W         = 16;
    localparam int ADDR_W        = 4;
    localparam int APB_W         = 32;
    localparam int DIV_W         = 64;
    localparam int DEN_W         = 35;

    // register indexes
    localparam logic [1:0] REG_VP_W   = 2'd0;
    localparam logic [1:0] REG_VP_H   = 2'd1;
    localparam logic [1:0] REG_LINE_W = 2'd2;

    localparam logic [CFG_W-1:0] VP_W_RESET   = 16'd1;
    localparam logic [CFG_W-1:0] VP_H_RESET   = 16'd1;
    localparam logic [CFG_W-1:0] LINE_W_RESET = 16'd256;

    typedef struct packed {
        logic [CRD_W-1:0] sx;
        logic [CRD_W-1:0] sy;
        logic [CRD_W-1:0] sz;
        logic [CRD_W-1:0] sw;
        logic [CRD_W-1:0] ex;
        logic [CRD_W-1:0] ey;
        logic [CRD_W-1:0] ez;
        logic [CRD_W-1:0] ew;
        logic [COL_W-1:0] scol;
        logic [COL_W-1:0] ecol;
    } seg_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic [DIV_W-1:0] quo;
    } div_rsp_t;

endpackage

// File: sv/cetl_front.sv
// ----------------------------------------------------------------------------
// cetl_front
// Segment intake: two-entry queue that takes segments while the back end works.
// ----------------------------------------------------------------------------
module cetl_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          valid,
    output logic          stall,
    input  cetl_pkg::seg_t seg,
    output logic          q_valid,
    output cetl_pkg::seg_t q_data,
    input  logic          pop
);
    import cetl_pkg::*;

    seg_t       ent_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;

    assign stall   = (count_reg == 2'd2);
    assign push    = valid && !stall;
    assign q_valid = (count_reg != 2'd0);
    assign q_data  = ent_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= seg;
        end
    end

    ap_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != 2'd0)
        else $error("queue popped while empty");

    ap_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2 && !pop) |=> count_reg == 2'd2)
        else $error("queue lost an entry while full");

    ap_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count did not follow push");

endmodule

// File: sv/cetl_div.sv
// ----------------------------------------------------------------------------
// cetl_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cetl_div (
    input  logic               clk,
    input  logic               rst_n,
    input  cetl_pkg::div_req_t req,
    output cetl_pkg::div_rsp_t rsp
);
    import cetl_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] num_reg, num_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [DEN_W:0]   trial;

    assign trial    = {rem_reg[DEN_W-1:0], num_reg[DIV_W-1]};
    assign rsp.busy = busy_reg;
    assign rsp.quo  = quo_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W);
            num_next  = req.num;
            den_next  = req.den;
            rem_next  = '0;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

endmodule

// File: sv/cetl_back.sv
// ----------------------------------------------------------------------------
// cetl_back
// Sequencer: plane clipping, perspective divide, pixel length, quad emission.
// ----------------------------------------------------------------------------
module cetl_back #(
    parameter int FRAC_BITS = cetl_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  cetl_pkg::seg_t                q_data,
    output logic                          pop,
    input  logic [cetl_pkg::CFG_W-1:0]    vp_w,
    input  logic [cetl_pkg::CFG_W-1:0]    vp_h,
    input  logic [cetl_pkg::CFG_W-1:0]    line_w,
    output cetl_pkg::div_req_t            div_req,
    input  cetl_pkg::div_rsp_t            div_rsp,
    output logic                          vert_valid,
    input  logic                          vert_stall,
    output logic signed [cetl_pkg::CRD_W-1:0] vert_x,
    output logic signed [cetl_pkg::CRD_W-1:0] vert_y,
    output logic signed [cetl_pkg::CRD_W-1:0] vert_z,
    output logic [cetl_pkg::COL_W-1:0]    vert_color,
    output logic                          last_vertex
);
    import cetl_pkg::*;

    localparam int OFF_SHIFT = T_BITS + 8 - FRAC_BITS;
    localparam int OFF_W     = 47 - OFF_SHIFT;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_PLANE = 5'd1;
    localparam logic [4:0] S_TDIV = 5'd2;
    localparam logic [4:0] S_HM0 = 5'd3;
    localparam logic [4:0] S_HM1 = 5'd4;
    localparam logic [4:0] S_HM2 = 5'd5;
    localparam logic [4:0] S_WCHK = 5'd6;
    localparam logic [4:0] S_NST = 5'd7;
    localparam logic [4:0] S_NDIV = 5'd8;
    localparam logic [4:0] S_DM0 = 5'd9;
    localparam logic [4:0] S_DM1 = 5'd10;
    localparam logic [4:0] S_DM2 = 5'd11;
    localparam logic [4:0] S_NORM = 5'd12;
    localparam logic [4:0] S_SQ0 = 5'd13;
    localparam logic [4:0] S_SQ1 = 5'd14;
    localparam logic [4:0] S_SQ2 = 5'd15;
    localparam logic [4:0] S_SQRT = 5'd16;
    localparam logic [4:0] S_UX = 5'd17;
    localparam logic [4:0] S_UXW = 5'd18;
    localparam logic [4:0] S_UYW = 5'd19;
    localparam logic [4:0] S_OM = 5'd20;
    localparam logic [4:0] S_OXD = 5'd21;
    localparam logic [4:0] S_OXW = 5'd22;
    localparam logic [4:0] S_OYW = 5'd23;
    localparam logic [4:0] S_EMIT = 5'd24;

    // vertex order p0+, p0-, p1+, p1+, p0-, p1-
    localparam logic [5:0] WHICH = 6'b101100;
    localparam logic [5:0] MINUS = 6'b110010;

    function automatic logic [31:0] sat40(input logic [39:0] v);
        logic [31:0] r;
        begin
            r = v[31:0];
            if (!v[39] && (v[38:31] != 8'h00))
            begin
                r = 32'h7fff_ffff;
            end
            else if (v[39] && (v[38:31] != 8'hff))
            begin
                r = 32'h8000_0000;
            end
            return r;
        end
    endfunction

    function automatic logic [30:0] cap_one(input logic [DIV_W-1:0] q);
        logic [30:0] r;
        begin
            r = q[30:0];
            if ((q[DIV_W-1:31] != '0) || (q[30] && (q[29:0] != '0)))
            begin
                r = {1'b1, 30'b0};
            end
            return r;
        end
    endfunction

    logic [4:0]              state_reg, state_next;
    logic [3:0][31:0]        a_reg, a_next;
    logic [3:0][31:0]        b_reg, b_next;
    logic [COL_W-1:0]        col0_reg, col0_next, col1_reg, col1_next;
    logic [2:0]              plane_reg, plane_next;
    logic [1:0]              k_reg, k_next;
    logic                    e_reg, e_next;
    logic [1:0]              c_reg, c_next;
    logic [2:0]              vtx_reg, vtx_next;
    logic                    d0neg_reg, d0neg_next;
    logic [30:0]             t_reg, t_next;
    logic [63:0]             mul_reg, mul_next;
    logic [63:0]             acc_reg, acc_next;
    logic [1:0][2:0][31:0]   n_reg, n_next;
    logic [48:0]             ax_reg, ax_next, ay_reg, ay_next;
    logic                    dxneg_reg, dxneg_next, dypos_reg, dypos_next;
    logic [62:0]             sq_v_reg, sq_v_next, sq_res_reg, sq_res_next;
    logic [62:0]             sq_bit_reg, sq_bit_next;
    logic [30:0]             ux_reg, ux_next, uy_reg, uy_next;
    logic [OFF_W-1:0]        offx_reg, offx_next, offy_reg, offy_next;
    logic                    vert_valid_reg, vert_valid_next;
    logic [31:0]             vx_reg, vx_next, vy_reg, vy_next, vz_reg, vz_next;
    logic [COL_W-1:0]        vcol_reg, vcol_next;
    logic                    vlast_reg, vlast_next;

    logic [CFG_W-1:0] vw, vh;
    logic [33:0]      mul_a;
    logic [30:0]      mul_b;
    logic [64:0]      prod;
    logic             out_load;

    // plane distances
    logic [1:0]        axis;
    logic [31:0]       c0, c1, w0, w1;
    logic signed [33:0] d0, d1;
    logic signed [34:0] dden;
    logic [33:0]       d0_neg;
    logic [34:0]       dden_neg;

    // intersection
    logic [31:0]       ak, bk;
    logic [32:0]       delta, delta_mag;
    logic [63:0]       hsum;
    logic [33:0]       hm, hit;

    // perspective divide
    logic [31:0]       cv, wv, cmag, wmag, ndc;
    logic              ndc_neg, ndc_big;

    // pixel deltas
    logic [32:0]       dfx, dfy, dfx_mag, dfy_mag;
    logic [48:0]       mmax;
    logic [62:0]       sq_trial;

    // vertex
    logic              ve, vmn;
    logic [31:0]       nx, ny;
    logic [39:0]       offx_ext, offy_ext, addx, addy, sumx, sumy;

    assign vw = (vp_w == '0) ? CFG_W'(1) : vp_w;
    assign vh = (vp_h == '0) ? CFG_W'(1) : vp_h;
    assign prod = 65'(mul_a) * 65'(mul_b);

    assign axis   = plane_reg[2:1];
    assign c0     = a_reg[axis];
    assign c1     = b_reg[axis];
    assign w0     = a_reg[3];
    assign w1     = b_reg[3];
    assign d0     = plane_reg[0] ? ($signed({{2{w0[31]}}, w0}) - $signed({{2{c0[31]}}, c0}))
                                 : ($signed({{2{w0[31]}}, w0}) + $signed({{2{c0[31]}}, c0}));
    assign d1     = plane_reg[0] ? ($signed({{2{w1[31]}}, w1}) - $signed({{2{c1[31]}}, c1}))
                                 : ($signed({{2{w1[31]}}, w1}) + $signed({{2{c1[31]}}, c1}));
    assign dden   = $signed({d0[33], d0}) - $signed({d1[33], d1});
    assign d0_neg = ~d0 + 34'd1;
    assign dden_neg = ~dden + 35'd1;

    assign ak        = a_reg[k_reg];
    assign bk        = b_reg[k_reg];
    assign delta     = {bk[31], bk} - {ak[31], ak};
    assign delta_mag = delta[32] ? (~delta + 33'd1) : delta;
    assign hsum      = acc_reg + {mul_reg[47:0], 16'b0};
    assign hm        = {1'b0, hsum[62:30]};
    assign hit       = {{2{ak[31]}}, ak} + (delta[32] ? (~hm + 34'd1) : hm);

    assign cv      = e_reg ? b_reg[c_reg] : a_reg[c_reg];
    assign wv      = e_reg ? b_reg[3] : a_reg[3];
    assign cmag    = cv[31] ? (~cv + 32'd1) : cv;
    assign wmag    = wv[31] ? (~wv + 32'd1) : wv;
    assign ndc_neg = cv[31] ^ wv[31];
    assign ndc_big = (div_rsp.quo[DIV_W-1:31] != '0);
    assign ndc     = ndc_neg ? (ndc_big ? 32'h8000_0000 : (~div_rsp.quo[31:0] + 32'd1))
                             : (ndc_big ? 32'h7fff_ffff : div_rsp.quo[31:0]);

    assign dfx     = {n_reg[1][0][31], n_reg[1][0]} - {n_reg[0][0][31], n_reg[0][0]};
    assign dfy     = {n_reg[1][1][31], n_reg[1][1]} - {n_reg[0][1][31], n_reg[0][1]};
    assign dfx_mag = dfx[32] ? (~dfx + 33'd1) : dfx;
    assign dfy_mag = dfy[32] ? (~dfy + 33'd1) : dfy;
    assign mmax    = (ax_reg > ay_reg) ? ax_reg : ay_reg;
    assign sq_trial = sq_res_reg + sq_bit_reg;

    assign ve       = WHICH[vtx_reg];
    assign vmn      = MINUS[vtx_reg];
    assign nx       = n_reg[ve][0];
    assign ny       = n_reg[ve][1];
    assign offx_ext = 40'(offx_reg);
    assign offy_ext = 40'(offy_reg);
    assign addx     = (dypos_reg ^ vmn) ? (~offx_ext + 40'd1) : offx_ext;
    assign addy     = (dxneg_reg ^ vmn) ? (~offy_ext + 40'd1) : offy_ext;
    assign sumx     = {{8{nx[31]}}, nx} + addx;
    assign sumy     = {{8{ny[31]}}, ny} + addy;

    assign out_load = (state_reg == S_EMIT) && (!vert_valid_reg || !vert_stall);
    assign pop      = (state_reg == S_IDLE) && q_valid;

    always_comb
    begin
        state_next      = state_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        col0_next       = col0_reg;
        col1_next       = col1_reg;
        plane_next      = plane_reg;
        k_next          = k_reg;
        e_next          = e_reg;
        c_next          = c_reg;
        vtx_next        = vtx_reg;
        d0neg_next      = d0neg_reg;
        t_next          = t_reg;
        mul_next        = mul_reg;
        acc_next        = acc_reg;
        n_next          = n_reg;
        ax_next         = ax_reg;
        ay_next         = ay_reg;
        dxneg_next      = dxneg_reg;
        dypos_next      = dypos_reg;
        sq_v_next       = sq_v_reg;
        sq_res_next     = sq_res_reg;
        sq_bit_next     = sq_bit_reg;
        ux_next         = ux_reg;
        uy_next         = uy_reg;
        offx_next       = offx_reg;
        offy_next       = offy_reg;
        vx_next         = vx_reg;
        vy_next         = vy_reg;
        vz_next         = vz_reg;
        vcol_next       = vcol_reg;
        vlast_next      = vlast_reg;
        vert_valid_next = vert_valid_reg && vert_stall;
        mul_a           = '0;
        mul_b           = '0;
        div_req.start   = 1'b0;
        div_req.num     = '0;
        div_req.den     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    a_next     = {q_data.sw, q_data.sz, q_data.sy, q_data.sx};
                    b_next     = {q_data.ew, q_data.ez, q_data.ey, q_data.ex};
                    col0_next  = q_data.scol;
                    col1_next  = q_data.ecol;
                    plane_next = 3'd0;
                    state_next = S_PLANE;
                end
            end
            S_PLANE:
            begin
                if (d0[33] && d1[33])
                begin
                    state_next = S_IDLE;
                end
                else if (d0[33] || d1[33])
                begin
                    if (dden == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        d0neg_next    = d0[33];
                        div_req.start = 1'b1;
                        div_req.num   = 64'({(d0[33] ? d0_neg[32:0] : d0[32:0]),
                                             {T_BITS{1'b0}}});
                        div_req.den   = dden[34] ? dden_neg : dden;
                        state_next    = S_TDIV;
                    end
                end
                else if (plane_reg == 3'd5)
                begin
                    state_next = S_WCHK;
                end
                else
                begin
                    plane_next = plane_reg + 3'd1;
                end
            end
            S_TDIV:
            begin
                if (!div_rsp.busy)
                begin
                    t_next     = div_rsp.quo[30:0];
                    k_next     = 2'd0;
                    state_next = S_HM0;
                end
            end
            S_HM0:
            begin
                mul_a      = {1'b0, delta_mag};
                mul_b      = {15'b0, t_reg[15:0]};
                mul_next   = prod[63:0];
                state_next = S_HM1;
            end
            S_HM1:
            begin
                acc_next   = mul_reg;
                mul_a      = {1'b0, delta_mag};
                mul_b      = {16'b0, t_reg[30:16]};
                mul_next   = prod[63:0];
                state_next = S_HM2;
            end
            S_HM2:
            begin
                if (d0neg_reg)
                begin
                    a_next[k_reg] = hit[31:0];
                end
                else
                begin
                    b_next[k_reg] = hit[31:0];
                end
                if (k_reg == 2'd3)
                begin
                    if (plane_reg == 3'd5)
                    begin
                        state_next = S_WCHK;
                    end
                    else
                    begin
                        plane_next = plane_reg + 3'd1;
                        state_next = S_PLANE;
                    end
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_HM0;
                end
            end
            S_WCHK:
            begin
                if ((a_reg[3] == '0) || (b_reg[3] == '0))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    e_next     = 1'b0;
                    c_next     = 2'd0;
                    state_next = S_NST;
                end
            end
            S_NST:
            begin
                div_req.start = 1'b1;
                div_req.num   = 64'({cmag, {FRAC_BITS{1'b0}}});
                div_req.den   = 35'(wmag);
                state_next    = S_NDIV;
            end
            S_NDIV:
            begin
                if (!div_rsp.busy)
                begin
                    n_next[e_reg][c_reg] = ndc;
                    if (c_reg == 2'd2)
                    begin
                        c_next = 2'd0;
                        e_next = 1'b1;
                        state_next = e_reg ? S_DM0 : S_NST;
                    end
                    else
                    begin
                        c_next     = c_reg + 2'd1;
                        state_next = S_NST;
                    end
                end
            end
            S_DM0:
            begin
                mul_a      = {1'b0, dfx_mag};
                mul_b      = 31'(vw);
                mul_next   = prod[63:0];
                dxneg_next = dfx[32];
                state_next = S_DM1;
            end
            S_DM1:
            begin
                ax_next    = mul_reg[48:0];
                mul_a      = {1'b0, dfy_mag};
                mul_b      = 31'(vh);
                mul_next   = prod[63:0];
                dypos_next = !dfy[32] && (dfy != '0);
                state_next = S_DM2;
            end
            S_DM2:
            begin
                ay_next    = mul_reg[48:0];
                state_next = S_NORM;
            end
            S_NORM:
            begin
                // bring the larger delta into [2^29, 2^30)
                if ((ax_reg == '0) && (ay_reg == '0))
                begin
                    state_next = S_IDLE;
                end
                else if (mmax[48:30] != '0)
                begin
                    ax_next = ax_reg >> 1;
                    ay_next = ay_reg >> 1;
                end
                else if (!mmax[29])
                begin
                    ax_next = ax_reg << 1;
                    ay_next = ay_reg << 1;
                end
                else
                begin
                    state_next = S_SQ0;
                end
            end
            S_SQ0:
            begin
                mul_a      = 34'(ax_reg[29:0]);
                mul_b      = 31'(ax_reg[29:0]);
                mul_next   = prod[63:0];
                state_next = S_SQ1;
            end
            S_SQ1:
            begin
                sq_v_next  = mul_reg[62:0];
                mul_a      = 34'(ay_reg[29:0]);
                mul_b      = 31'(ay_reg[29:0]);
                mul_next   = prod[63:0];
                state_next = S_SQ2;
            end
            S_SQ2:
            begin
                sq_v_next   = sq_v_reg + mul_reg[62:0];
                sq_res_next = '0;
                sq_bit_next = {1'b1, 62'b0};
                state_next  = S_SQRT;
            end
            S_SQRT:
            begin
                if (sq_v_reg >= sq_trial)
                begin
                    sq_v_next   = sq_v_reg - sq_trial;
                    sq_res_next = (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_res_next = sq_res_reg >> 1;
                end
                sq_bit_next = sq_bit_reg >> 2;
                if (sq_bit_reg[0])
                begin
                    state_next = S_UX;
                end
            end
            S_UX:
            begin
                div_req.start = 1'b1;
                div_req.num   = 64'({ay_reg[29:0], {T_BITS{1'b0}}});
                div_req.den   = 35'(sq_res_reg[31:0]);
                state_next    = S_UXW;
            end
            S_UXW:
            begin
                if (!div_rsp.busy)
                begin
                    ux_next       = cap_one(div_rsp.quo);
                    div_req.start = 1'b1;
                    div_req.num   = 64'({ax_reg[29:0], {T_BITS{1'b0}}});
                    div_req.den   = 35'(sq_res_reg[31:0]);
                    state_next    = S_UYW;
                end
            end
            S_UYW:
            begin
                if (!div_rsp.busy)
                begin
                    uy_next    = cap_one(div_rsp.quo);
                    state_next = S_OM;
                end
            end
            S_OM:
            begin
                mul_a      = 34'(ux_reg);
                mul_b      = 31'(line_w);
                mul_next   = prod[63:0];
                state_next = S_OXD;
            end
            S_OXD:
            begin
                // the viewport scale divides out after the fixed shift
                div_req.start = 1'b1;
                div_req.num   = mul_reg >> OFF_SHIFT;
                div_req.den   = 35'(vw);
                mul_a         = 34'(uy_reg);
                mul_b         = 31'(line_w);
                mul_next      = prod[63:0];
                state_next    = S_OXW;
            end
            S_OXW:
            begin
                if (!div_rsp.busy)
                begin
                    offx_next     = div_rsp.quo[OFF_W-1:0];
                    div_req.start = 1'b1;
                    div_req.num   = mul_reg >> OFF_SHIFT;
                    div_req.den   = 35'(vh);
                    state_next    = S_OYW;
                end
            end
            S_OYW:
            begin
                if (!div_rsp.busy)
                begin
                    offy_next  = div_rsp.quo[OFF_W-1:0];
                    vtx_next   = 3'd0;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    vert_valid_next = 1'b1;
                    vx_next         = sat40(sumx);
                    vy_next         = sat40(sumy);
                    vz_next         = n_reg[ve][2];
                    vcol_next       = ve ? col1_reg : col0_reg;
                    vlast_next      = (vtx_reg == 3'd5);
                    vtx_next        = vtx_reg + 3'd1;
                    if (vtx_reg == 3'd5)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            vert_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            vert_valid_reg <= vert_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        col0_reg   <= col0_next;
        col1_reg   <= col1_next;
        plane_reg  <= plane_next;
        k_reg      <= k_next;
        e_reg      <= e_next;
        c_reg      <= c_next;
        vtx_reg    <= vtx_next;
        d0neg_reg  <= d0neg_next;
        t_reg      <= t_next;
        mul_reg    <= mul_next;
        acc_reg    <= acc_next;
        n_reg      <= n_next;
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        dxneg_reg  <= dxneg_next;
        dypos_reg  <= dypos_next;
        sq_v_reg   <= sq_v_next;
        sq_res_reg <= sq_res_next;
        sq_bit_reg <= sq_bit_next;
        ux_reg     <= ux_next;
        uy_reg     <= uy_next;
        offx_reg   <= offx_next;
        offy_reg   <= offy_next;
        vx_reg     <= vx_next;
        vy_reg     <= vy_next;
        vz_reg     <= vz_next;
        vcol_reg   <= vcol_next;
        vlast_reg  <= vlast_next;
    end

    assign vert_valid  = vert_valid_reg;
    assign vert_x      = vx_reg;
    assign vert_y      = vy_reg;
    assign vert_z      = vz_reg;
    assign vert_color  = vcol_reg;
    assign last_vertex = vlast_reg;

    ap_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

    ap_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |=> div_rsp.busy)
        else $error("divider did not start");

    ap_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !(vert_valid_reg && vert_stall))
        else $error("held vertex overwritten");

    ap_sqrt_bit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SQRT |-> sq_bit_reg != '0)
        else $error("square root ran past its last step");

endmodule

// File: sv/clip_and_expand_thick_line_top.sv
// ----------------------------------------------------------------------------
// clip_and_expand_thick_line_top
// Homogeneous line clipping with thick line quad expansion.
// ----------------------------------------------------------------------------
// usage:
//   segment channel: seg_valid/seg_stall carries one segment per transaction,
//   two clip-space endpoints in Q16.16 plus one packed RGB color each.
//   vertex channel: vert_valid/vert_stall carries one vertex per transaction;
//   a kept segment gives six vertices (two triangles), last_vertex on the
//   sixth; a segment clipped away or of zero pixel length gives none.
//   APB port sets viewport width (0x0), viewport height (0x4) and line width
//   in Q8.8 pixels (0x8); write only while the block is idle.
//   the shared 64-step divider runs up to 16 times per segment (clip
//   parameters, perspective divides, unit perpendicular, offsets) and sets
//   the throughput.
//   a two-entry queue takes new segments while one is worked on; the vertex
//   output register holds while vert_stall is high and the sequencer waits.
//   reset empties the queue, drops any segment in flight and sets the
//   registers to viewport 1 x 1 and line width 1.0
// ----------------------------------------------------------------------------
module clip_and_expand_thick_line_top #(
    parameter int FRAC_BITS = cetl_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cetl_pkg::ADDR_W-1:0]        paddr,
    input  logic [cetl_pkg::APB_W-1:0]         pwdata,
    output logic [cetl_pkg::APB_W-1:0]         prdata,
    output logic                               pready,
    input  logic                               seg_valid,
    output logic                               seg_stall,
    input  logic signed [cetl_pkg::CRD_W-1:0]  start_x,
    input  logic signed [cetl_pkg::CRD_W-1:0]  start_y,
    input  logic signed [cetl_pkg::CRD_W-1:0]  start_z,
    input  logic signed [cetl_pkg::CRD_W-1:0]  start_w,
    input  logic signed [cetl_pkg::CRD_W-1:0]  end_x,
    input  logic signed [cetl_pkg::CRD_W-1:0]  end_y,
    input  logic signed [cetl_pkg::CRD_W-1:0]  end_z,
    input  logic signed [cetl_pkg::CRD_W-1:0]  end_w,
    input  logic [cetl_pkg::COL_W-1:0]         start_color,
    input  logic [cetl_pkg::COL_W-1:0]         end_color,
    output logic                               vert_valid,
    input  logic                               vert_stall,
    output logic signed [cetl_pkg::CRD_W-1:0]  vert_x,
    output logic signed [cetl_pkg::CRD_W-1:0]  vert_y,
    output logic signed [cetl_pkg::CRD_W-1:0]  vert_z,
    output logic [cetl_pkg::COL_W-1:0]         vert_color,
    output logic                               last_vertex
);
    import cetl_pkg::*;

    logic [CFG_W-1:0] vp_w_reg, vp_w_next;
    logic [CFG_W-1:0] vp_h_reg, vp_h_next;
    logic [CFG_W-1:0] line_w_reg, line_w_next;
    logic             cfg_wr;
    seg_t             seg;
    seg_t             q_data;
    logic             q_valid;
    logic             pop;
    div_req_t         div_req;
    div_rsp_t         div_rsp;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        vp_w_next   = vp_w_reg;
        vp_h_next   = vp_h_reg;
        line_w_next = line_w_reg;
        if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_VP_W:   vp_w_next   = pwdata[CFG_W-1:0];
                REG_VP_H:   vp_h_next   = pwdata[CFG_W-1:0];
                REG_LINE_W: line_w_next = pwdata[CFG_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_VP_W:   prdata = APB_W'(vp_w_reg);
            REG_VP_H:   prdata = APB_W'(vp_h_reg);
            REG_LINE_W: prdata = APB_W'(line_w_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_w_reg   <= VP_W_RESET;
            vp_h_reg   <= VP_H_RESET;
            line_w_reg <= LINE_W_RESET;
        end
        else
        begin
            vp_w_reg   <= vp_w_next;
            vp_h_reg   <= vp_h_next;
            line_w_reg <= line_w_next;
        end
    end

    assign seg.sx   = start_x;
    assign seg.sy   = start_y;
    assign seg.sz   = start_z;
    assign seg.sw   = start_w;
    assign seg.ex   = end_x;
    assign seg.ey   = end_y;
    assign seg.ez   = end_z;
    assign seg.ew   = end_w;
    assign seg.scol = start_color;
    assign seg.ecol = end_color;

    cetl_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .valid   (seg_valid),
        .stall   (seg_stall),
        .seg     (seg),
        .q_valid (q_valid),
        .q_data  (q_data),
        .pop     (pop)
    );

    cetl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    cetl_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_data      (q_data),
        .pop         (pop),
        .vp_w        (vp_w_reg),
        .vp_h        (vp_h_reg),
        .line_w      (line_w_reg),
        .div_req     (div_req),
        .div_rsp     (div_rsp),
        .vert_valid  (vert_valid),
        .vert_stall  (vert_stall),
        .vert_x      (vert_x),
        .vert_y      (vert_y),
        .vert_z      (vert_z),
        .vert_color  (vert_color),
        .last_vertex (last_vertex)
    );

endmodule
